// ===== hdl/cdd_pkg.sv =====
// Shared widths and types for the constant-divisor divider.
// No dependencies; every other file of the block depends on this package.
package cdd_pkg;

  localparam int DATA_W  = 16;
  localparam int SHIFT_W = 4;
  localparam int PROD_W  = 2 * DATA_W;
  // The reciprocal division walks one numerator bit per cycle over 2*DATA_W bits.
  localparam int CNT_W   = $clog2(PROD_W);

  typedef logic [DATA_W-1:0]  data_t;
  typedef logic [SHIFT_W-1:0] shift_t;
  typedef logic [PROD_W-1:0]  prod_t;
  typedef logic [CNT_W-1:0]   cnt_t;

endpackage

// ===== hdl/cdd_in_if.sv =====
// Dividend channel of the constant-divisor divider: valid, ready and payload.
// Depends on cdd_pkg for the payload width.
interface cdd_in_if;
  logic           valid;
  logic           ready;
  cdd_pkg::data_t dividend;

  modport source (output valid, output dividend, input ready);
  modport sink   (input valid, input dividend, output ready);
endinterface

// ===== hdl/cdd_out_if.sv =====
// Result channel of the constant-divisor divider: valid, ready and payload.
// Depends on cdd_pkg for the payload widths.
interface cdd_out_if;
  logic            valid;
  logic            ready;
  cdd_pkg::data_t  quotient;
  cdd_pkg::data_t  multiplier_used;
  cdd_pkg::data_t  addend_used;
  cdd_pkg::shift_t shift_used;

  modport source (output valid, output quotient, output multiplier_used,
                  output addend_used, output shift_used, input ready);
  modport sink   (input valid, input quotient, input multiplier_used,
                  input addend_used, input shift_used, output ready);
endinterface

// ===== hdl/constant_divisor_divider.sv =====
// Unsigned divider by a configured divisor using a precomputed multiply-add-shift.
// Depends on cdd_pkg, cdd_in_if and cdd_out_if.
//
// Usage:
//   cfg_we / cfg_wdata write the divisor. A zero divisor is ignored. A nonzero
//   write starts the derivation of the magic multiplier, addend and shift: a
//   bit-serial reciprocal division, a multiply step and a select step.
//   in_ch.ready is low during that time.
//   Write the divisor only when no item is in flight.
//   in_ch carries dividends, out_ch carries the quotient together with the
//   constants that produced it. An item is moved when valid and ready are high.
//   An accepted item passes the operand, product, sum and shift stages to
//   out_ch.valid. One item per cycle is sustained while no derivation runs and
//   out_ch.ready is high; the 16x16 multiplier stage sets the rate and takes a
//   new operand every cycle. With out_ch.ready low the stages fill up in turn
//   and in_ch.ready falls once all four are full; nothing is dropped or repeated.
//   Reset (rst_n low, synchronous) empties the pipeline and loads the
//   constants for a divisor of one.
module constant_divisor_divider (
  input  logic           clk,
  input  logic           rst_n,
  cdd_in_if.sink         in_ch,
  cdd_out_if.source      out_ch,
  input  logic           cfg_we,
  input  cdd_pkg::data_t cfg_wdata
);
  import cdd_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_MUL  = 2'd2;
  localparam logic [1:0] ST_SEL  = 2'd3;

  function automatic shift_t log2_floor(input data_t v);
    shift_t r;
    r = '0;
    for (int i = 0; i < DATA_W; i++) begin
      if (v[i]) r = shift_t'(i);
    end
    return r;
  endfunction

  // ---------------- constant derivation ----------------
  logic [1:0] state_r;
  data_t      div_r;
  shift_t     l_r;
  cnt_t       cnt_r;
  data_t      rem_r;
  data_t      quo_r;
  data_t      up_r;
  data_t      wrap_r;
  data_t      magic_mul_r;
  data_t      magic_add_r;
  shift_t     magic_shift_r;

  logic              num_bit;
  logic [DATA_W:0]   rem_sh;
  logic              rem_ge;
  data_t             rem_nxt;
  data_t             quo_nxt;
  data_t             up_nxt;
  prod_t             wrap_prod;
  data_t             pow_l;
  logic              is_pow2;
  logic              busy;
  logic              cfg_start;

  assign cfg_start = cfg_we && (cfg_wdata != '0);
  assign busy      = (state_r != ST_IDLE);

  // The numerator 2^(DATA_W+l) has a single one bit.
  assign num_bit = (cnt_r == (cnt_t'(DATA_W) + cnt_t'(l_r)));
  assign rem_sh  = {rem_r, num_bit};
  assign rem_ge  = (rem_sh >= {1'b0, div_r});
  assign rem_nxt = rem_ge ? data_t'(rem_sh - {1'b0, div_r}) : data_t'(rem_sh);
  assign quo_nxt = {quo_r[DATA_W-2:0], rem_ge};

  assign up_nxt    = quo_r + data_t'(1);
  assign wrap_prod = prod_t'(up_nxt) * prod_t'(div_r);
  assign pow_l     = data_t'(1) << l_r;
  assign is_pow2   = ((div_r & (div_r - data_t'(1))) == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      div_r         <= data_t'(1);
      l_r           <= '0;
      cnt_r         <= '0;
      magic_mul_r   <= '1;
      magic_add_r   <= '1;
      magic_shift_r <= '0;
    end else if (cfg_start) begin
      div_r   <= cfg_wdata;
      l_r     <= log2_floor(cfg_wdata);
      cnt_r   <= cnt_t'(PROD_W - 1);
      state_r <= ST_DIV;
    end else begin
      case (state_r)
        ST_IDLE: begin
          state_r <= ST_IDLE;
        end
        ST_DIV: begin
          cnt_r <= cnt_r - cnt_t'(1);
          if (cnt_r == '0) state_r <= ST_MUL;
        end
        ST_MUL: begin
          state_r <= ST_SEL;
        end
        ST_SEL: begin
          if (is_pow2) begin
            magic_mul_r <= '1;
            magic_add_r <= '1;
          end else if (wrap_r <= pow_l) begin
            magic_mul_r <= up_r;
            magic_add_r <= '0;
          end else begin
            magic_mul_r <= quo_r;
            magic_add_r <= quo_r;
          end
          magic_shift_r <= l_r;
          state_r       <= ST_IDLE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // Datapath of the derivation; the controller above decides when it moves.
  always_ff @(posedge clk) begin
    if (cfg_start) begin
      rem_r <= '0;
      quo_r <= '0;
    end else if (state_r == ST_DIV) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
    if (state_r == ST_MUL) begin
      up_r   <= up_nxt;
      wrap_r <= wrap_prod[DATA_W-1:0];
    end
  end

  // ---------------- dividend pipeline ----------------
  logic   s1_v_r, s2_v_r, s3_v_r, s4_v_r;
  logic   rdy1, rdy2, rdy3, rdy4;
  logic   in_fire;
  data_t  s1_n_r, s1_mul_r, s1_add_r;
  shift_t s1_sh_r;
  prod_t  s2_prod_r;
  data_t  s2_mul_r, s2_add_r;
  shift_t s2_sh_r;
  data_t  s3_hi_r, s3_mul_r, s3_add_r;
  shift_t s3_sh_r;
  data_t  s4_q_r, s4_mul_r, s4_add_r;
  shift_t s4_sh_r;
  prod_t  s3_sum;

  assign rdy4    = !s4_v_r || out_ch.ready;
  assign rdy3    = !s3_v_r || rdy4;
  assign rdy2    = !s2_v_r || rdy3;
  assign rdy1    = !s1_v_r || rdy2;
  assign in_ch.ready = rdy1 && !busy;
  assign in_fire = in_ch.valid && in_ch.ready;

  // n*mul + add stays below 2^(2*DATA_W), so the sum cannot overflow.
  assign s3_sum = s2_prod_r + prod_t'(s2_add_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else begin
      if (rdy1) s1_v_r <= in_fire;
      if (rdy2) s2_v_r <= s1_v_r;
      if (rdy3) s3_v_r <= s2_v_r;
      if (rdy4) s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_fire) begin
      s1_n_r   <= in_ch.dividend;
      s1_mul_r <= magic_mul_r;
      s1_add_r <= magic_add_r;
      s1_sh_r  <= magic_shift_r;
    end
    if (rdy2 && s1_v_r) begin
      s2_prod_r <= prod_t'(s1_n_r) * prod_t'(s1_mul_r);
      s2_mul_r  <= s1_mul_r;
      s2_add_r  <= s1_add_r;
      s2_sh_r   <= s1_sh_r;
    end
    if (rdy3 && s2_v_r) begin
      s3_hi_r  <= s3_sum[PROD_W-1:DATA_W];
      s3_mul_r <= s2_mul_r;
      s3_add_r <= s2_add_r;
      s3_sh_r  <= s2_sh_r;
    end
    if (rdy4 && s3_v_r) begin
      s4_q_r   <= s3_hi_r >> s3_sh_r;
      s4_mul_r <= s3_mul_r;
      s4_add_r <= s3_add_r;
      s4_sh_r  <= s3_sh_r;
    end
  end

  assign out_ch.valid           = s4_v_r;
  assign out_ch.quotient        = s4_q_r;
  assign out_ch.multiplier_used = s4_mul_r;
  assign out_ch.addend_used     = s4_add_r;
  assign out_ch.shift_used      = s4_sh_r;

`ifndef SYNTHESIS
  a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !in_ch.ready)
    else $error("dividend accepted while constants are being derived");

  a_write_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_start |=> (state_r == ST_DIV))
    else $error("divisor write did not start the derivation");

  a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (rem_r < div_r))
    else $error("division remainder reached the divisor");

  a_magic_stable_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) && !cfg_start |=>
      $stable(magic_mul_r) && $stable(magic_add_r) && $stable(magic_shift_r))
    else $error("magic constants changed without a divisor write");

  a_accept_fills_stage1: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> s1_v_r)
    else $error("accepted dividend was lost at the first stage");
`endif

endmodule

// ===== tb/sv/cdd_checker.sv =====
// Result checker for the constant-divisor divider: predicts every item and compares outputs.
// Depends on cdd_pkg and on the cdd_in_if and cdd_out_if channel interfaces.
`timescale 1ns / 100ps

module cdd_checker (
  input  logic           clk,
  input  logic           rst_n,
  cdd_in_if              in_ch,
  cdd_out_if             out_ch,
  input  logic           cfg_we,
  input  cdd_pkg::data_t cfg_wdata,
  output int             mismatches,
  output int             outstanding
);
  import cdd_pkg::*;

  typedef struct packed {
    data_t  mul;
    data_t  add;
    shift_t shift;
  } magic_t;

  typedef struct packed {
    data_t  quotient;
    data_t  multiplier_used;
    data_t  addend_used;
    shift_t shift_used;
  } div_result_t;

  magic_t      magic;
  div_result_t quotient_q[$];
  int          errors = 0;

  // Multiplier, addend and shift for an invariant divisor d (d is never zero here).
  function automatic magic_t derive_magic(input data_t d);
    magic_t      k;
    int unsigned l;
    logic [63:0] down;
    logic [63:0] up;
    logic [63:0] wrapped;
    l = 0;
    for (int i = 0; i < DATA_W; i++) begin
      if (d[i]) l = i;
    end
    k.shift = shift_t'(l);
    if ((d & (d - data_t'(1))) == '0) begin
      k.mul = '1;
      k.add = '1;
    end else begin
      down    = (64'd1 << (DATA_W + l)) / 64'(d);
      up      = (down + 64'd1) & 64'hFFFF;
      wrapped = (up * 64'(d)) & 64'hFFFF;
      // Round-up multiplier when its error stays within 2^l, else round down and add.
      if (wrapped <= (64'd1 << l)) begin
        k.mul = up[DATA_W-1:0];
        k.add = '0;
      end else begin
        k.mul = down[DATA_W-1:0];
        k.add = down[DATA_W-1:0];
      end
    end
    return k;
  endfunction

  function automatic div_result_t divide_by_magic(input data_t n, input magic_t k);
    div_result_t r;
    logic [63:0] full;
    full              = 64'(n) * 64'(k.mul) + 64'(k.add);
    r.quotient        = data_t'((full >> DATA_W) >> k.shift);
    r.multiplier_used = k.mul;
    r.addend_used     = k.add;
    r.shift_used      = k.shift;
    return r;
  endfunction

  always @(posedge clk) begin
    div_result_t got;
    div_result_t want;
    if (!rst_n) begin
      magic = derive_magic(data_t'(1));
      quotient_q.delete();
    end else begin
      // Pop before push: an item accepted at this edge cannot already be at the output.
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.quotient, out_ch.multiplier_used, out_ch.addend_used,
                out_ch.shift_used};
        if (quotient_q.size() == 0) begin
          if (errors < 10)
            $display("%0t: unexpected item q=%0d mul=%0d add=%0d sh=%0d", $realtime,
                     got.quotient, got.multiplier_used, got.addend_used, got.shift_used);
          errors++;
        end else begin
          want = quotient_q.pop_front();
          if (got.quotient !== want.quotient || got.multiplier_used !== want.multiplier_used ||
              got.addend_used !== want.addend_used || got.shift_used !== want.shift_used) begin
            if (errors < 10)
              $display({"%0t: expected q=%0d mul=%0d add=%0d sh=%0d,",
                        " got q=%0d mul=%0d add=%0d sh=%0d"},
                       $realtime, want.quotient, want.multiplier_used, want.addend_used,
                       want.shift_used, got.quotient, got.multiplier_used, got.addend_used,
                       got.shift_used);
            errors++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready)
        quotient_q.push_back(divide_by_magic(in_ch.dividend, magic));
      // A zero divisor is ignored and the previous constants stay.
      if (cfg_we && cfg_wdata != '0)
        magic = derive_magic(cfg_wdata);
    end
    mismatches  <= errors;
    outstanding <= quotient_q.size();
  end

endmodule

// ===== tb/sv/tb.sv =====
// Testbench top for the constant-divisor divider: clock, reset, stimulus and verdict.
// Depends on cdd_pkg, the channel interfaces, the block itself and cdd_checker.
`timescale 1ns / 100ps

module tb;
  import cdd_pkg::*;

  typedef enum int unsigned {
    READY_ALWAYS,
    READY_COIN,
    READY_SPARSE,
    READY_PERIODIC
  } stall_mode_e;

  logic  clk;
  logic  rst_n;
  logic  cfg_we;
  data_t cfg_wdata;
  int    mismatches;
  int    outstanding;

  cdd_in_if  in_if ();
  cdd_out_if out_if ();

  constant_divisor_divider i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  cdd_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_if),
    .out_ch      (out_if),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  data_t       divisor_now = 16'd1;
  int unsigned burst_left  = 0;
  stall_mode_e ready_mode  = READY_ALWAYS;
  int unsigned mode_left   = 0;
  int unsigned tick        = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // The receiver switches between stall patterns at random intervals.
  always @(posedge clk) begin
    if (mode_left == 0) begin
      ready_mode = stall_mode_e'($urandom_range(0, 3));
      mode_left  = $urandom_range(20, 200);
    end else begin
      mode_left--;
    end
    tick++;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      case (ready_mode)
        READY_ALWAYS: out_if.ready <= 1'b1;
        READY_COIN:   out_if.ready <= 1'($urandom_range(0, 1));
        READY_SPARSE: out_if.ready <= ($urandom_range(0, 3) == 0);
        default:      out_if.ready <= (tick % 5) != 0;
      endcase
    end
  end

  // Presents one dividend until an edge accepts it; at the end of a burst it also idles with valid low.
  task automatic feed_dividend(input data_t n);
    in_if.valid    <= 1'b1;
    in_if.dividend <= n;
    do @(posedge clk); while (!in_if.ready);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end else begin
      burst_left--;
    end
  endtask

  task automatic wait_for_results();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (8) @(posedge clk);
  endtask

  // Only called with the pipeline empty and no item offered.
  task automatic write_divisor(input data_t d);
    cfg_we    <= 1'b1;
    cfg_wdata <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (d != '0) divisor_now = d;
  endtask

  function automatic data_t pick_divisor();
    int unsigned p;
    p = 1 << $urandom_range(2, 15);
    case ($urandom_range(0, 7))
      0:       return data_t'(1);
      1:       return '1;
      2:       return data_t'($urandom_range(2, 16));
      3:       return data_t'(1 << $urandom_range(1, 15));
      4:       return data_t'($urandom_range(0, 1) ? p + 1 : p - 1);
      5:       return '0;
      default: return data_t'($urandom_range(1, 65535));
    endcase
  endfunction

  // Some dividends are multiples of d or one less, where rounding errors would show.
  function automatic data_t pick_dividend(input data_t d);
    int unsigned q;
    int unsigned n;
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3: begin
        q = $urandom_range(0, 65535 / d);
        n = q * d;
        if ($urandom_range(0, 1) && n != 0) n = n - 1;
        return data_t'(n);
      end
      default: return data_t'($urandom);
    endcase
  endfunction

  initial begin
    int unsigned items_sent;
    int unsigned phase_len;
    int unsigned phase_no;
    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_wdata      <= '0;
    in_if.valid    <= 1'b0;
    in_if.dividend <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    wait_for_results();

    // Divisor one straight out of reset.
    feed_dividend(16'd0);
    feed_dividend(16'hFFFF);
    feed_dividend(16'd1);
    feed_dividend(16'hAAAA);
    feed_dividend(16'h5555);
    // Seven takes the round-down multiplier with an addend.
    wait_for_results();
    write_divisor(16'd7);
    feed_dividend(16'd0);
    feed_dividend(16'd6);
    feed_dividend(16'd7);
    feed_dividend(16'hFFFF);
    // Three takes the round-up multiplier without an addend.
    wait_for_results();
    write_divisor(16'd3);
    feed_dividend(16'hFFFF);
    feed_dividend(16'd2);
    feed_dividend(16'd3);
    // A zero write must leave the divisor of three in place.
    wait_for_results();
    write_divisor(16'd0);
    feed_dividend(16'hFFFF);
    feed_dividend(16'd5);
    wait_for_results();
    write_divisor(16'hFFFF);
    feed_dividend(16'hFFFE);
    feed_dividend(16'hFFFF);
    wait_for_results();
    write_divisor(16'h8000);
    feed_dividend(16'h7FFF);
    feed_dividend(16'h8000);
    feed_dividend(16'hFFFF);
    wait_for_results();
    write_divisor(16'h8001);
    feed_dividend(16'hFFFF);
    feed_dividend(16'h8001);

    items_sent = 0;
    phase_no   = 0;
    while (items_sent < 1400) begin
      phase_len = $urandom_range(40, 160);
      wait_for_results();
      write_divisor(pick_divisor());
      for (int i = 0; i < phase_len; i++) begin
        if (i == phase_len / 2 && phase_no % 3 == 1) wait_for_results();
        feed_dividend(pick_dividend(divisor_now));
      end
      items_sent += phase_len;
      phase_no++;
    end

    wait_for_results();
    if (mismatches == 0 && outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
